// File: hw/rtl/pcc_pkg.sv
package pcc_pkg;

	localparam int NUM_CHAMBERS_DEF = 3;
	localparam int MAX_CHAMBERS     = 3;

	localparam logic [10:0] FULL_SCALE_PM = 11'd1000;
	localparam logic [10:0] PCT_CAP_PM    = 11'd995;
	localparam logic [6:0]  PCT_MAX       = 7'd100;
	localparam logic [7:0]  SETTLE_RESET  = 8'd20;
	localparam logic [7:0]  DUTY_RESET    = 8'd255;

	localparam logic REG_SETTLE = 1'b0;
	localparam logic REG_DUTY   = 1'b1;

	typedef enum logic [2:0] {
		ACT_TICK         = 3'd0,
		ACT_INFLATE      = 3'd1,
		ACT_DEFLATE      = 3'd2,
		ACT_SET_PRESSURE = 3'd3,
		ACT_SET_MAX      = 3'd4,
		ACT_HOLD         = 3'd5,
		ACT_SAMPLE       = 3'd6
	} act_t;

	typedef enum logic [2:0] {
		MODE_IDLE   = 3'd0,
		MODE_PREINF = 3'd1,
		MODE_PREDEF = 3'd2,
		MODE_INFL   = 3'd3,
		MODE_DEFL   = 3'd4
	} mode_t;

	typedef struct packed {
		logic [2:0]         action;
		logic [1:0]         chamber;
		logic signed [15:0] param;
		logic [10:0]        sample;
	} cmd_t;

	typedef struct packed {
		logic [2:0] inflate_valves;
		logic [2:0] deflate_valves;
		logic [7:0] pump_duty;
		logic       vacuum_on;
		logic [2:0] chamber_mode;
		logic [6:0] pressure_pct;
		logic       dropped;
	} res_t;

	typedef struct packed {
		logic [7:0] settle_ticks;
		logic [7:0] inflate_duty;
	} cfg_t;

	typedef struct packed {
		logic        en;
		act_t        action;
		logic [10:0] p_pm;
		logic [10:0] smp;
		logic [7:0]  settle_ticks;
		logic [7:0]  inflate_duty;
	} ch_ctl_t;

	typedef struct packed {
		mode_t       mode;
		logic [7:0]  duty;
		logic [10:0] last_pressure;
	} ch_stat_t;

	function automatic logic [10:0] pct_to_pm(input logic signed [15:0] p);
		logic [10:0] r;
		if (p < 16'sd0) begin
			r = 11'd0;
		end else if (p > 16'sd100) begin
			r = FULL_SCALE_PM;
		end else begin
			r = 11'(p[6:0]) * 11'd10;
		end
		return r;
	endfunction

	// round to percent: (pm + 5) / 10 by reciprocal 205 / 2048, exact below the cap
	function automatic logic [6:0] pct_round(input logic [10:0] pm);
		logic [19:0] prod;
		logic [6:0]  r;
		prod = (20'(pm) + 20'd5) * 20'd205;
		if (pm >= PCT_CAP_PM) begin
			r = PCT_MAX;
		end else begin
			r = prod[17:11];
		end
		return r;
	endfunction

endpackage

// File: hw/rtl/pcc_regs.sv
module pcc_regs (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             psel,
	input  logic             penable,
	input  logic             pwrite,
	input  logic [2:0]       paddr,
	input  logic [31:0]      pwdata,
	output logic [31:0]      prdata,
	output logic             pready,
	output pcc_pkg::cfg_t    cfg
);
	import pcc_pkg::*;

	logic [7:0] settle_q;
	logic [7:0] duty_q;
	logic       wr;

	assign pready = 1'b1;
	assign wr     = psel && penable && pwrite;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			settle_q <= SETTLE_RESET;
			duty_q   <= DUTY_RESET;
		end else if (wr) begin
			case (paddr[2])
				REG_SETTLE: settle_q <= pwdata[7:0];
				REG_DUTY:   duty_q   <= pwdata[7:0];
				default: ;
			endcase
		end
	end

	always_comb begin
		case (paddr[2])
			REG_SETTLE: prdata = {24'd0, settle_q};
			REG_DUTY:   prdata = {24'd0, duty_q};
			default:    prdata = 32'd0;
		endcase
	end

	assign cfg.settle_ticks = settle_q;
	assign cfg.inflate_duty = duty_q;

endmodule

// File: hw/rtl/pcc_chamber.sv
module pcc_chamber (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               sel,
	input  pcc_pkg::ch_ctl_t   ctl,
	output pcc_pkg::ch_stat_t  stat
);
	import pcc_pkg::*;

	mode_t       mode_q, mode_nxt;
	logic [7:0]  duty_q, duty_nxt;
	logic [10:0] target_q, target_nxt;
	logic [10:0] limit_q, limit_nxt;
	logic [7:0]  settle_q, settle_nxt;
	logic [10:0] last_q, last_nxt;

	logic        inf_go, def_go, stop;
	logic [10:0] t_req, t_clip;
	logic [11:0] sum;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mode_q   <= MODE_IDLE;
			duty_q   <= 8'd0;
			target_q <= 11'd0;
			limit_q  <= FULL_SCALE_PM;
			settle_q <= 8'd0;
			last_q   <= 11'd0;
		end else begin
			mode_q   <= mode_nxt;
			duty_q   <= duty_nxt;
			target_q <= target_nxt;
			limit_q  <= limit_nxt;
			settle_q <= settle_nxt;
			last_q   <= last_nxt;
		end
	end

	always_comb begin
		mode_nxt   = mode_q;
		duty_nxt   = duty_q;
		target_nxt = target_q;
		limit_nxt  = limit_q;
		settle_nxt = settle_q;
		last_nxt   = last_q;
		inf_go     = 1'b0;
		def_go     = 1'b0;
		stop       = 1'b0;
		t_req      = 11'd0;
		sum        = 12'(last_q) + 12'(ctl.p_pm);

		if (ctl.en && ctl.action == ACT_TICK) begin
			if (mode_q == MODE_PREINF || mode_q == MODE_PREDEF) begin
				if (settle_q > 8'd1) begin
					settle_nxt = settle_q - 8'd1;
				end else begin
					settle_nxt = 8'd0;
					mode_nxt   = (mode_q == MODE_PREINF) ? MODE_INFL : MODE_DEFL;
				end
			end
		end else if (ctl.en && sel) begin
			case (ctl.action)
				ACT_INFLATE: begin
					inf_go = 1'b1;
					t_req  = (sum > 12'(limit_q)) ? limit_q : sum[10:0];
				end
				ACT_DEFLATE: begin
					def_go = 1'b1;
					t_req  = (last_q > ctl.p_pm) ? last_q - ctl.p_pm : 11'd0;
				end
				ACT_SET_PRESSURE: begin
					t_req = (ctl.p_pm > limit_q) ? limit_q : ctl.p_pm;
					if (last_q < t_req) begin
						inf_go = 1'b1;
					end else if (last_q > t_req) begin
						def_go = 1'b1;
					end else begin
						stop = 1'b1;
					end
				end
				ACT_SET_MAX: begin
					limit_nxt = ctl.p_pm;
					stop      = (mode_q == MODE_INFL) && (last_q >= ctl.p_pm);
				end
				ACT_HOLD: begin
					stop = 1'b1;
				end
				ACT_SAMPLE: begin
					last_nxt = ctl.smp;
					stop = ((mode_q == MODE_INFL) && (ctl.smp >= target_q || ctl.smp >= limit_q))
						|| ((mode_q == MODE_DEFL) && (ctl.smp <= target_q));
				end
				default: ;
			endcase
		end

		t_clip = (t_req > limit_q) ? limit_q : t_req;

		if (inf_go && !(mode_q == MODE_INFL && target_q == t_clip)) begin
			duty_nxt   = ctl.inflate_duty;
			target_nxt = t_clip;
			if (mode_q == MODE_DEFL || mode_q == MODE_PREDEF) begin
				mode_nxt   = MODE_PREINF;
				settle_nxt = ctl.settle_ticks;
			end else begin
				mode_nxt = MODE_INFL;
			end
		end

		if (def_go && !(mode_q == MODE_DEFL && target_q == t_clip)) begin
			target_nxt = t_clip;
			if (mode_q == MODE_INFL || mode_q == MODE_PREINF) begin
				mode_nxt   = MODE_PREDEF;
				settle_nxt = ctl.settle_ticks;
			end else begin
				mode_nxt = MODE_DEFL;
			end
		end

		if (stop) begin
			mode_nxt   = MODE_IDLE;
			duty_nxt   = 8'd0;
			target_nxt = 11'd0;
			settle_nxt = 8'd0;
		end
	end

	assign stat.mode          = mode_nxt;
	assign stat.duty          = duty_nxt;
	assign stat.last_pressure = last_nxt;

endmodule

// File: hw/rtl/pneumatic_chamber_controller.sv
// channel | dir | handshake             | payload
// cmd     | in  | cmd_valid / cmd_ready | cmd_t: action, chamber, param, sample
// res     | out | res_valid / res_ready | res_t: valves, pump, vacuum, mode, pct, dropped
// cfg     | in  | APB psel / penable    | settle_ticks at 0x0, inflate_duty at 0x4
//
// One beat in, one beat out; a beat can be accepted every cycle while the result is not stalled.
// A beat passes through the input register, then chamber update and the result register.
// The chamber state is updated in the same cycle the result register loads,
// so the next beat sees it at once.
// A stalled result holds the input register; reset puts every chamber idle, max 1000.
module pneumatic_chamber_controller #(
	parameter int NUM_CHAMBERS = pcc_pkg::NUM_CHAMBERS_DEF
) (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          cmd_valid,
	output logic          cmd_ready,
	input  pcc_pkg::cmd_t cmd,
	output logic          res_valid,
	input  logic          res_ready,
	output pcc_pkg::res_t res,
	input  logic          psel,
	input  logic          penable,
	input  logic          pwrite,
	input  logic [2:0]    paddr,
	input  logic [31:0]   pwdata,
	output logic [31:0]   prdata,
	output logic          pready
);
	import pcc_pkg::*;

	cfg_t     cfg;
	cmd_t     cmd_s1;
	logic     valid_s1;
	logic     advance;
	ch_ctl_t  ctl;
	ch_stat_t stat [NUM_CHAMBERS];
	logic     ch_ok;
	res_t     res_d;

	pcc_regs u_regs (
		.clk    (clk),
		.arst_n (arst_n),
		.psel   (psel),
		.penable(penable),
		.pwrite (pwrite),
		.paddr  (paddr),
		.pwdata (pwdata),
		.prdata (prdata),
		.pready (pready),
		.cfg    (cfg)
	);

	assign advance   = valid_s1 && (!res_valid || res_ready);
	assign cmd_ready = !valid_s1 || advance;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (cmd_ready) begin
			valid_s1 <= cmd_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd_ready && cmd_valid) begin
			cmd_s1 <= cmd;
		end
	end

	assign ch_ok = int'(cmd_s1.chamber) < NUM_CHAMBERS;

	assign ctl.en           = advance;
	assign ctl.action       = act_t'(cmd_s1.action);
	assign ctl.p_pm         = pct_to_pm(cmd_s1.param);
	assign ctl.smp          = cmd_s1.sample;
	assign ctl.settle_ticks = cfg.settle_ticks;
	assign ctl.inflate_duty = cfg.inflate_duty;

	for (genvar g = 0; g < NUM_CHAMBERS; g++) begin : g_ch
		pcc_chamber u_ch (
			.clk   (clk),
			.arst_n(arst_n),
			.sel   (int'(cmd_s1.chamber) == g),
			.ctl   (ctl),
			.stat  (stat[g])
		);
	end

	always_comb begin
		res_d = '0;
		for (int i = 0; i < NUM_CHAMBERS; i++) begin
			if (stat[i].mode == MODE_INFL) begin
				res_d.inflate_valves[i] = 1'b1;
				if (stat[i].duty > res_d.pump_duty) begin
					res_d.pump_duty = stat[i].duty;
				end
			end
			if (stat[i].mode == MODE_DEFL) begin
				res_d.deflate_valves[i] = 1'b1;
			end
			if (int'(cmd_s1.chamber) == i) begin
				res_d.chamber_mode = stat[i].mode;
				res_d.pressure_pct = pct_round(stat[i].last_pressure);
			end
		end
		res_d.vacuum_on = res_d.deflate_valves != 3'b000;
		res_d.dropped   = !ch_ok && cmd_s1.action != ACT_TICK && cmd_s1.action <= ACT_SAMPLE;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			res_valid <= 1'b0;
		end else if (advance) begin
			res_valid <= 1'b1;
		end else if (res_ready) begin
			res_valid <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (advance) begin
			res <= res_d;
		end
	end

	a_valves_excl: assert property (@(posedge clk) disable iff (!arst_n)
		res_valid |-> (res.inflate_valves & res.deflate_valves) == 3'b000)
		else $error("inflate and deflate valves open together");

	a_vacuum: assert property (@(posedge clk) disable iff (!arst_n)
		res_valid |-> res.vacuum_on == (res.deflate_valves != 3'b000))
		else $error("vacuum does not follow deflate valves");

	a_pump_off: assert property (@(posedge clk) disable iff (!arst_n)
		res_valid && res.inflate_valves == 3'b000 |-> res.pump_duty == 8'd0)
		else $error("pump running with no inflate valve");

	a_load_s1: assert property (@(posedge clk) disable iff (!arst_n)
		cmd_valid && cmd_ready |=> valid_s1)
		else $error("accepted beat lost before input register");

	a_ready_empty: assert property (@(posedge clk) disable iff (!arst_n)
		!valid_s1 |-> cmd_ready)
		else $error("ready low with empty input register");

endmodule
